FILE: src/ffpa_pkg.sv
// Shared constants, types and codes for the first-fit page allocator.
`default_nettype none

package ffpa_pkg;

	localparam int NUM_PAGES = 1024;
	localparam int PAGE_W    = $clog2(NUM_PAGES);
	localparam int CNT_W     = $clog2(NUM_PAGES + 1);

	typedef logic [PAGE_W-1:0] page_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_BAD      = 2'd2
	} status_t;

	typedef struct packed {
		logic free;
		cnt_t len;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic   we;
		page_t  waddr;
		entry_t wdata;
		page_t  raddr;
	} mem_req_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_A_SCAN,
		S_A_CLR,
		S_A_TAIL,
		S_F_CHK,
		S_F_END,
		S_F_PREV,
		S_F_WALK,
		S_F_WR,
		S_F_ENDWR,
		S_F_HEADWR
	} state_t;

endpackage

`default_nettype wire

FILE: src/ffpa_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
`default_nettype none

module ffpa_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: src/ffpa_ctrl.sv
// Request sequencer: scan, check, merge walk and write-back over the page table.
`default_nettype none

module ffpa_ctrl
	import ffpa_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic       mode,
	input  wire cnt_t       page_count,
	input  wire page_t      start_index,
	input  wire logic       zero_fill,
	output logic            busy,
	output logic            done,
	output logic [1:0]      status,
	output page_t           first_page,
	output cnt_t            pages_free,
	output logic            zero_request,
	output mem_req_t        mem_req,
	input  wire entry_t     rdata
);

	state_t  state_q, state_d;
	page_t   idx_q, h_q, start_q, first_q;
	cnt_t    count_q, end_q, len_q, lsum_q, total_q;
	logic    zero_q, end_free_q, merge_q;
	logic    done_q, zreq_q;
	status_t status_q;

	logic                 fin, total_inc, total_dec, fin_zreq;
	status_t              fin_status;
	page_t                fin_first;
	logic [CNT_W:0]       end_w;
	logic                 a_bad, a_nospc, f_bad;
	logic                 last, scan_hit, walk_go, end_free_w, last_page;
	page_t                idx_next, h_dec;

	assign end_w      = (CNT_W+1)'(start_index) + (CNT_W+1)'(page_count);
	assign a_bad      = (page_count == '0) || (page_count > CNT_W'(NUM_PAGES));
	assign a_nospc    = page_count > total_q;
	assign f_bad      = (page_count == '0) || (end_w > (CNT_W+1)'(NUM_PAGES));
	assign idx_next   = idx_q + PAGE_W'(1);
	assign h_dec      = h_q - PAGE_W'(1);
	assign last       = (CNT_W'(idx_q) + CNT_W'(1)) == end_q;
	assign last_page  = idx_q == PAGE_W'(NUM_PAGES - 1);
	assign scan_hit   = rdata.free && (rdata.len >= count_q);
	assign walk_go    = (len_q == '0) && rdata.free;
	assign end_free_w = (end_q < CNT_W'(NUM_PAGES)) && rdata.free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (last_page) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					if (mode == MODE_ALLOC) begin
						state_d = (a_bad || a_nospc) ? S_IDLE : S_A_SCAN;
					end else begin
						state_d = f_bad ? S_IDLE : S_F_CHK;
					end
				end
			end
			S_A_SCAN: begin
				if (scan_hit) state_d = S_A_CLR;
				else if (last_page) state_d = S_IDLE;
			end
			S_A_CLR: begin
				if (last) state_d = (len_q > count_q) ? S_A_TAIL : S_IDLE;
			end
			S_A_TAIL: state_d = S_IDLE;
			S_F_CHK: begin
				if (rdata.free) state_d = S_IDLE;
				else if (last) state_d = S_F_END;
			end
			S_F_END: state_d = (start_q == '0) ? S_F_WR : S_F_PREV;
			S_F_PREV: begin
				if (!rdata.free || start_q == PAGE_W'(1)) state_d = S_F_WR;
				else state_d = S_F_WALK;
			end
			S_F_WALK: begin
				if (!(walk_go && h_dec != '0)) state_d = S_F_WR;
			end
			S_F_WR: begin
				if (last) begin
					if (end_free_q) state_d = S_F_ENDWR;
					else if (merge_q) state_d = S_F_HEADWR;
					else state_d = S_IDLE;
				end
			end
			S_F_ENDWR:  state_d = merge_q ? S_F_HEADWR : S_IDLE;
			S_F_HEADWR: state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		mem_req       = '0;
		mem_req.waddr = idx_q;
		fin           = 1'b0;
		fin_status    = ST_OK;
		fin_first     = '0;
		fin_zreq      = 1'b0;
		total_inc     = 1'b0;
		total_dec     = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				mem_req.we = 1'b1;
			end
			S_IDLE: begin
				mem_req.raddr = (mode == MODE_FREE) ? start_index : '0;
				if (start) begin
					if (mode == MODE_ALLOC) begin
						if (a_bad) begin
							fin        = 1'b1;
							fin_status = ST_BAD;
						end else if (a_nospc) begin
							fin        = 1'b1;
							fin_status = ST_NO_SPACE;
						end
					end else if (f_bad) begin
						fin        = 1'b1;
						fin_status = ST_BAD;
					end
				end
			end
			S_A_SCAN: begin
				mem_req.raddr = idx_next;
				if (!scan_hit && last_page) begin
					fin        = 1'b1;
					fin_status = ST_NO_SPACE;
				end
			end
			S_A_CLR: begin
				mem_req.we = 1'b1;
				if (last && !(len_q > count_q)) begin
					fin       = 1'b1;
					fin_first = h_q;
					fin_zreq  = zero_q;
					total_dec = 1'b1;
				end
			end
			S_A_TAIL: begin
				mem_req.we         = 1'b1;
				mem_req.waddr      = end_q[PAGE_W-1:0];
				mem_req.wdata.free = 1'b1;
				mem_req.wdata.len  = len_q - count_q;
				fin                = 1'b1;
				fin_first          = h_q;
				fin_zreq           = zero_q;
				total_dec          = 1'b1;
			end
			S_F_CHK: begin
				mem_req.raddr = idx_next;
				if (rdata.free) begin
					fin        = 1'b1;
					fin_status = ST_BAD;
				end
			end
			S_F_END: begin
				mem_req.raddr = start_q - PAGE_W'(1);
			end
			S_F_PREV: begin
				mem_req.raddr = start_q - PAGE_W'(2);
			end
			S_F_WALK: begin
				mem_req.raddr = h_q - PAGE_W'(2);
			end
			S_F_WR: begin
				mem_req.we         = 1'b1;
				mem_req.wdata.free = 1'b1;
				mem_req.wdata.len  = (idx_q == start_q && !merge_q) ? lsum_q : '0;
				if (last && !end_free_q && !merge_q) begin
					fin       = 1'b1;
					total_inc = 1'b1;
				end
			end
			S_F_ENDWR: begin
				mem_req.we         = 1'b1;
				mem_req.waddr      = end_q[PAGE_W-1:0];
				mem_req.wdata.free = 1'b1;
				if (!merge_q) begin
					fin       = 1'b1;
					total_inc = 1'b1;
				end
			end
			S_F_HEADWR: begin
				mem_req.we         = 1'b1;
				mem_req.waddr      = h_q;
				mem_req.wdata.free = 1'b1;
				mem_req.wdata.len  = len_q + lsum_q;
				fin                = 1'b1;
				total_inc          = 1'b1;
			end
			default: begin
				mem_req.we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			idx_q   <= '0;
			total_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (total_inc) total_q <= total_q + count_q;
			else if (total_dec) total_q <= total_q - count_q;
			case (state_q)
				S_CLEAR, S_A_CLR, S_F_CHK, S_F_WR: begin
					idx_q <= idx_next;
				end
				S_IDLE: begin
					if (start) idx_q <= (mode == MODE_FREE) ? start_index : '0;
				end
				S_A_SCAN: begin
					if (!scan_hit) idx_q <= idx_next;
				end
				S_F_END: begin
					idx_q <= start_q;
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			status_q <= fin_status;
			first_q  <= fin_first;
			zreq_q   <= fin_zreq;
		end
		case (state_q)
			S_IDLE: begin
				if (start) begin
					count_q <= page_count;
					start_q <= start_index;
					zero_q  <= zero_fill;
					end_q   <= end_w[CNT_W-1:0];
				end
			end
			S_A_SCAN: begin
				if (scan_hit) begin
					h_q   <= idx_q;
					len_q <= rdata.len;
					end_q <= CNT_W'(idx_q) + count_q;
				end
			end
			S_F_END: begin
				end_free_q <= end_free_w;
				lsum_q     <= count_q + (end_free_w ? rdata.len : '0);
				merge_q    <= 1'b0;
			end
			S_F_PREV: begin
				h_q     <= start_q - PAGE_W'(1);
				len_q   <= rdata.len;
				merge_q <= rdata.free && (start_q == PAGE_W'(1)) && (rdata.len != '0);
			end
			S_F_WALK: begin
				if (walk_go) begin
					h_q     <= h_dec;
					len_q   <= rdata.len;
					merge_q <= rdata.len != '0;
				end else begin
					merge_q <= len_q != '0;
				end
			end
			default: begin
				h_q <= h_q;
			end
		endcase
	end

	assign busy         = state_q != S_IDLE;
	assign done         = done_q;
	assign status       = status_q;
	assign first_page   = first_q;
	assign pages_free   = total_q;
	assign zero_request = zreq_q;

endmodule

`default_nettype wire

FILE: src/first_fit_page_allocator.sv
// Top level of the first-fit page allocator with run coalescing.
//
//  channel   | handshake                 | fields
//  ----------+---------------------------+--------------------------------------------
//  request   | start in, busy out        | mode, page_count, start_index, zero_fill
//  result    | done out, one-cycle pulse | status, first_page, pages_free, zero_request
//
//  One item at a time; page table in one 1024 x 12 RAM, one read and one write a cycle.
//  Allocate: a first-fit scan of up to NUM_PAGES entries, then page_count writes and up to one tail write.
//  Free: page_count check reads, a backward walk of up to start_index reads,
//  then page_count writes and up to two more, for the end entry and the merged head entry.
//  Bad or no-space requests decided up front finish without leaving the idle state.
//  After reset a clearing pass over all NUM_PAGES (1024) entries runs with busy high.
//  done cannot be held off; the result ports are valid only while done is high.
`default_nettype none

module first_fit_page_allocator
	import ffpa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              mode,
	input  wire logic [CNT_W-1:0]  page_count,
	input  wire logic [PAGE_W-1:0] start_index,
	input  wire logic              zero_fill,
	output logic                   done,
	output logic [1:0]             status,
	output logic [PAGE_W-1:0]      first_page,
	output logic [CNT_W-1:0]       pages_free,
	output logic                   zero_request
);

	mem_req_t             mem_req;
	logic [ENTRY_W-1:0]   ram_rdata;
	entry_t               rd_entry;

	assign rd_entry = entry_t'(ram_rdata);

	ffpa_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_PAGES)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr),
		.rdata (ram_rdata)
	);

	ffpa_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.mode         (mode),
		.page_count   (page_count),
		.start_index  (start_index),
		.zero_fill    (zero_fill),
		.busy         (busy),
		.done         (done),
		.status       (status),
		.first_page   (first_page),
		.pages_free   (pages_free),
		.zero_request (zero_request),
		.mem_req      (mem_req),
		.rdata        (rd_entry)
	);

endmodule

`default_nettype wire

FILE: src/ffpa_checker.sv
// Port-level checks for the page allocator and the bind that attaches them.
`default_nettype none

module ffpa_checker
	import ffpa_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              done,
	input wire logic [1:0]        status,
	input wire logic [PAGE_W-1:0] first_page,
	input wire logic [CNT_W-1:0]  pages_free,
	input wire logic              zero_request
);

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_accept_gives_work: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted item neither in progress nor finished");

	a_done_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !$past(done) && !$past(start)) |-> $past(busy))
		else $error("result without an item in progress");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((status == ST_OK || status == ST_NO_SPACE || status == ST_BAD)
			&& pages_free <= CNT_W'(NUM_PAGES)))
		else $error("status code or free total out of range");

	a_fail_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (first_page == '0 && !zero_request))
		else $error("failed request reports a page or a zero request");

endmodule

bind first_fit_page_allocator ffpa_checker u_ffpa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.status       (status),
	.first_page   (first_page),
	.pages_free   (pages_free),
	.zero_request (zero_request)
);

`default_nettype wire

FILE: tb/first_fit_page_allocator_tb.sv
`timescale 1ns / 100ps
// Testbench for the first-fit page allocator: directed and random requests checked against a page map tracker.

module first_fit_page_allocator_tb;
	import ffpa_pkg::*;

	localparam int LIMIT_CYCLES = 4_000_000;
	localparam int DRAIN_CYCLES = 2 * NUM_PAGES + 16;
	localparam int RANDOM_ITEMS = 555;

	typedef struct {
		status_t status;
		page_t   first_page;
		cnt_t    pages_free;
		logic    zero_request;
	} alloc_result_t;

	typedef struct {
		int first;
		int count;
	} page_run_t;

	class page_map_tracker;
		bit            free_bit[NUM_PAGES];
		int            run_len[NUM_PAGES];
		int            free_total;
		alloc_result_t pending_results[$];
		int            errors;
		int            checked;
		int            n_granted;
		int            n_freed;
		int            n_no_space;
		int            n_rejected;

		function new();
			foreach (free_bit[i]) begin
				free_bit[i] = 1'b0;
				run_len[i] = 0;
			end
			free_total = 0;
			errors = 0;
			checked = 0;
			n_granted = 0;
			n_freed = 0;
			n_no_space = 0;
			n_rejected = 0;
		endfunction

		function alloc_result_t make_result(status_t st, int first, logic zr);
			alloc_result_t r;
			r.status = st;
			r.first_page = page_t'(first);
			r.pages_free = cnt_t'(free_total);
			r.zero_request = zr;
			return r;
		endfunction

		function alloc_result_t predict_alloc(int count, logic zf);
			int run;
			if (count == 0 || count > NUM_PAGES)
				return make_result(ST_BAD, 0, 1'b0);
			if (count > free_total)
				return make_result(ST_NO_SPACE, 0, 1'b0);
			for (int i = 0; i < NUM_PAGES; i++) begin
				if (free_bit[i] && run_len[i] >= count) begin
					run = run_len[i];
					for (int k = 0; k < count; k++) begin
						free_bit[i + k] = 1'b0;
						run_len[i + k] = 0;
					end
					if (run > count)
						run_len[i + count] = run - count;
					free_total -= count;
					return make_result(ST_OK, i, zf);
				end
			end
			return make_result(ST_NO_SPACE, 0, 1'b0);
		endfunction

		function alloc_result_t predict_free(int first, int count);
			int last;
			int h;
			if (count == 0 || count > NUM_PAGES - first)
				return make_result(ST_BAD, 0, 1'b0);
			last = first + count;
			for (int k = first; k < last; k++)
				if (free_bit[k])
					return make_result(ST_BAD, 0, 1'b0);
			for (int k = first; k < last; k++) begin
				free_bit[k] = 1'b1;
				run_len[k] = 0;
			end
			run_len[first] = count;
			if (last < NUM_PAGES && free_bit[last]) begin
				run_len[first] += run_len[last];
				run_len[last] = 0;
			end
			if (first > 0 && free_bit[first - 1]) begin
				h = first - 1;
				while (h > 0 && run_len[h] == 0 && free_bit[h - 1])
					h--;
				if (run_len[h] != 0) begin
					run_len[h] += run_len[first];
					run_len[first] = 0;
				end
			end
			free_total += count;
			return make_result(ST_OK, 0, 1'b0);
		endfunction

		function alloc_result_t note_request(logic m, int count, int first, logic zf);
			alloc_result_t r;
			if (m == MODE_ALLOC)
				r = predict_alloc(count, zf);
			else
				r = predict_free(first, count);
			case (r.status)
				ST_OK: begin
					if (m == MODE_ALLOC)
						n_granted++;
					else
						n_freed++;
				end
				ST_NO_SPACE: n_no_space++;
				default: n_rejected++;
			endcase
			pending_results.push_back(r);
			return r;
		endfunction

		function void check_result(logic [1:0] st, page_t fp, cnt_t pf, logic zr);
			alloc_result_t e;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: status %0d first_page %0d pages_free %0d",
					$time, st, fp, pf);
				errors++;
				return;
			end
			e = pending_results.pop_front();
			checked++;
			if (st !== e.status) begin
				$display("%0t: status expected %0d actual %0d", $time, e.status, st);
				errors++;
			end
			if (fp !== e.first_page) begin
				$display("%0t: first_page expected %0d actual %0d", $time, e.first_page, fp);
				errors++;
			end
			if (pf !== e.pages_free) begin
				$display("%0t: pages_free expected %0d actual %0d", $time, e.pages_free, pf);
				errors++;
			end
			if (zr !== e.zero_request) begin
				$display("%0t: zero_request expected %0b actual %0b", $time, e.zero_request, zr);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        mode = MODE_ALLOC;
	cnt_t        page_count = '0;
	page_t       start_index = '0;
	logic        zero_fill = 1'b0;
	logic        busy;
	logic        done;
	logic [1:0]  status;
	page_t       first_page;
	cnt_t        pages_free;
	logic        zero_request;

	page_map_tracker board;
	page_run_t       live_runs[$];
	int              burst_left = 0;
	int              cycle_count = 0;

	first_fit_page_allocator DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.page_count   (page_count),
		.start_index  (start_index),
		.zero_fill    (zero_fill),
		.done         (done),
		.status       (status),
		.first_page   (first_page),
		.pages_free   (pages_free),
		.zero_request (zero_request)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			board.check_result(status, first_page, pages_free, zero_request);
	end

	task automatic send_request(input logic m, input int count, input int first, input logic zf);
		alloc_result_t r;
		page_run_t     run;
		start       <= 1'b1;
		mode        <= m;
		page_count  <= cnt_t'(count);
		start_index <= page_t'(first);
		zero_fill   <= zf;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		r = board.note_request(m, count, first, zf);
		if (m == MODE_ALLOC && r.status == ST_OK) begin
			run.first = int'(r.first_page);
			run.count = count;
			live_runs.push_back(run);
		end
		@(negedge clk);
	endtask

	task automatic pace();
		int gap;
		int pick;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			pick = $urandom_range(0, 99);
			if (pick < 25)
				gap = 0;
			else if (pick < 85)
				gap = $urandom_range(1, 40);
			else
				gap = $urandom_range(41, 400);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic random_request();
		int        pick;
		int        idx;
		int        cut;
		int        count;
		page_run_t run;
		pick = $urandom_range(0, 99);
		if (live_runs.size() == 0 || pick < 45) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				count = $urandom_range(1, 16);
			else if (pick < 90)
				count = $urandom_range(17, 128);
			else if (pick < 98)
				count = $urandom_range(129, NUM_PAGES);
			else if ($urandom_range(0, 1))
				count = 0;
			else
				count = $urandom_range(NUM_PAGES + 1, 2047);
			send_request(MODE_ALLOC, count, $urandom_range(0, NUM_PAGES - 1),
				1'($urandom_range(0, 1)));
		end else if (pick < 88) begin
			idx = $urandom_range(0, live_runs.size() - 1);
			run = live_runs[idx];
			live_runs.delete(idx);
			if (pick < 80 || run.count == 1) begin
				send_request(MODE_FREE, run.count, run.first, 1'($urandom_range(0, 1)));
			end else begin
				cut = $urandom_range(1, run.count - 1);
				if ($urandom_range(0, 1)) begin
					send_request(MODE_FREE, cut, run.first, 1'($urandom_range(0, 1)));
					run.first += cut;
					run.count -= cut;
				end else begin
					send_request(MODE_FREE, run.count - cut, run.first + cut,
						1'($urandom_range(0, 1)));
					run.count = cut;
				end
				live_runs.push_back(run);
			end
		end else begin
			if ($urandom_range(0, 3) == 0)
				count = $urandom_range(0, 2047);
			else
				count = $urandom_range(0, 8);
			send_request(MODE_FREE, count, $urandom_range(0, NUM_PAGES - 1),
				1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		board = new();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		pace(); send_request(MODE_ALLOC, 1, 0, 1'b0);
		pace(); send_request(MODE_ALLOC, 0, 0, 1'b1);
		pace(); send_request(MODE_ALLOC, 2047, NUM_PAGES - 1, 1'b1);
		pace(); send_request(MODE_FREE, 0, 0, 1'b0);
		pace(); send_request(MODE_FREE, 2, NUM_PAGES - 1, 1'b0);
		pace(); send_request(MODE_FREE, NUM_PAGES, 0, 1'b0);
		pace(); send_request(MODE_FREE, 1, NUM_PAGES - 1, 1'b1);
		pace(); send_request(MODE_ALLOC, NUM_PAGES, 0, 1'b1);
		pace(); send_request(MODE_ALLOC, 1, 0, 1'b0);
		pace(); send_request(MODE_FREE, 1, NUM_PAGES - 1, 1'b0);
		pace(); send_request(MODE_FREE, 1, 0, 1'b0);
		pace(); send_request(MODE_FREE, 1, 2, 1'b0);
		pace(); send_request(MODE_ALLOC, 2, 0, 1'b1);
		pace(); send_request(MODE_FREE, 1, 1, 1'b0);
		pace(); send_request(MODE_ALLOC, 4, 0, 1'b0);
		pace(); send_request(MODE_FREE, NUM_PAGES - 4, 3, 1'b0);
		pace(); send_request(MODE_FREE, 10, 500, 1'b0);
		pace(); send_request(MODE_ALLOC, 1000, 0, 1'b0);
		pace(); send_request(MODE_ALLOC, 24, 0, 1'b1);
		pace(); send_request(MODE_FREE, 24, 1000, 1'b0);
		pace(); send_request(MODE_FREE, 20, 990, 1'b0);
		pace(); send_request(MODE_FREE, 10, 990, 1'b0);
		pace(); send_request(MODE_ALLOC, 35, 0, 1'b0);
		pace(); send_request(MODE_ALLOC, 34, 0, 1'b1);
		pace(); send_request(MODE_FREE, NUM_PAGES, 0, 1'b0);
		live_runs.delete();

		repeat (RANDOM_ITEMS) begin
			pace();
			random_request();
		end
		start <= 1'b0;

		while (board.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Requests: %0d allocations granted, %0d frees done, %0d no-space, %0d rejected.",
			board.n_granted, board.n_freed, board.n_no_space, board.n_rejected);
		$display("Results checked: %0d, mismatches: %0d, pages free at end: %0d.",
			board.checked, board.errors, board.free_total);
		if (board.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: files.f
src/ffpa_pkg.sv
src/ffpa_ram.sv
src/ffpa_ctrl.sv
src/first_fit_page_allocator.sv
src/ffpa_checker.sv
tb/first_fit_page_allocator_tb.sv
